FILE: rtl/hwrf_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hwrf_pkg
// Shared types and constants of the high-water register free list: opcodes,
// status codes, sequencer states and the control links between modules.
// ---------------------------------------------------------------------------
package hwrf_pkg;

  localparam int REG_LIMIT = 255;
  localparam int MARK_MAX  = 255;
  localparam logic [7:0] MARK_LIMIT = 8'((REG_LIMIT < MARK_MAX) ? REG_LIMIT : MARK_MAX);

  localparam int WORD_BITS = 64;
  localparam int NUM_WORDS = 4;
  localparam int IDX_W     = $clog2(WORD_BITS);
  localparam int WSEL_W    = $clog2(NUM_WORDS);

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_BAD_FREE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FREE,
    S_COMPACT,
    S_SEARCH,
    S_DONE
  } state_t;

  typedef struct packed {
    logic in_valid;
    logic op_free;
    logic run;
    logic found;
    logic exhausted;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic in_ready;
    logic do_free;
    logic do_compact;
    logic sel_compact;
    logic do_search;
    logic load_out;
  } ctl_t;

endpackage

FILE: rtl/hwrf_scan.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hwrf_scan
// Shared 64-bit scan unit: finds the lowest set bit of one word.
// ---------------------------------------------------------------------------
module hwrf_scan (
  input  logic [hwrf_pkg::WORD_BITS-1:0] vec,
  output logic                           found,
  output logic [hwrf_pkg::IDX_W-1:0]     idx
);

  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = hwrf_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (vec[i]) begin
        found = 1'b1;
        idx   = hwrf_pkg::IDX_W'(i);
      end
    end
  end

endmodule

FILE: rtl/hwrf_fsm.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hwrf_fsm
// Sequencer: runs a free in one step, an allocate as compaction passes
// followed by word-by-word search, then hands the result to the output slot.
// ---------------------------------------------------------------------------
module hwrf_fsm (
  input  logic           clk,
  input  logic           rst,
  input  hwrf_pkg::sts_t sts,
  output hwrf_pkg::ctl_t ctl
);

  hwrf_pkg::state_t state;
  hwrf_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hwrf_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      hwrf_pkg::S_IDLE: begin
        if (sts.in_valid) begin
          state_next = sts.op_free ? hwrf_pkg::S_FREE : hwrf_pkg::S_COMPACT;
        end
      end
      hwrf_pkg::S_FREE: begin
        state_next = hwrf_pkg::S_DONE;
      end
      hwrf_pkg::S_COMPACT: begin
        if (!sts.run) begin
          state_next = hwrf_pkg::S_SEARCH;
        end
      end
      hwrf_pkg::S_SEARCH: begin
        if (sts.found || sts.exhausted) begin
          state_next = hwrf_pkg::S_DONE;
        end
      end
      hwrf_pkg::S_DONE: begin
        if (sts.out_free) begin
          state_next = hwrf_pkg::S_IDLE;
        end
      end
      default: state_next = hwrf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    unique case (state)
      hwrf_pkg::S_IDLE:    ctl.in_ready = 1'b1;
      hwrf_pkg::S_FREE:    ctl.do_free = 1'b1;
      hwrf_pkg::S_COMPACT: begin
        ctl.sel_compact = 1'b1;
        ctl.do_compact  = sts.run;
      end
      hwrf_pkg::S_SEARCH:  ctl.do_search = 1'b1;
      hwrf_pkg::S_DONE:    ctl.load_out = sts.out_free;
      default:             ctl = '0;
    endcase
  end

endmodule

FILE: rtl/high_water_register_free_list_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// high_water_register_free_list_core
// Register-number allocator with a high-water mark and a 256-bit free map.
// A free is done in its own free state; an allocate first runs compaction
// passes and then searches the map word by word, with the shared 64-bit scan
// unit handling one map word per cycle. Either result then moves to the output
// slot. The next input is taken only after that move, though it may be taken
// while the result still waits in the slot.
// Reset: mark, free count and free map are cleared directly, with no clearing pass.
// ---------------------------------------------------------------------------
module high_water_register_free_list_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       opcode,
  input  logic [7:0] reg_addr,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] given_reg,
  output logic [1:0] status,
  output logic [7:0] in_use_count,
  output logic [7:0] mark_out
);

  localparam int WB = hwrf_pkg::WORD_BITS;
  localparam int IW = hwrf_pkg::IDX_W;
  localparam int SW = hwrf_pkg::WSEL_W;

  hwrf_pkg::sts_t sts;
  hwrf_pkg::ctl_t ctl;

  logic [hwrf_pkg::NUM_WORDS-1:0][WB-1:0] free_map;
  logic [hwrf_pkg::NUM_WORDS-1:0][WB-1:0] free_map_next;
  logic [7:0] mark;
  logic [7:0] mark_next;
  logic [7:0] cnt;
  logic [7:0] cnt_next;
  logic [SW-1:0] widx;
  logic [SW-1:0] widx_next;
  logic [7:0] reg_q;
  logic op_free_q;
  logic [7:0] res_given;
  logic [7:0] res_given_next;
  hwrf_pkg::status_t res_status;
  hwrf_pkg::status_t res_status_next;

  logic [7:0]    top_pos;
  logic [SW-1:0] top_w;
  logic [IW-1:0] top_b;
  logic [WB-1:0] top_word;
  logic [WB-1:0] rev_inv;
  logic [WB-1:0] run_vec;
  logic [WB-1:0] scan_vec;
  logic          scan_found;
  logic [IW-1:0] scan_idx;
  logic [IW:0]   run_len;
  logic [IW:0]   keep_lo;
  logic [WB-1:0] keep_mask;
  logic          run;
  logic          cur_bit;
  logic          out_free;

  assign top_pos  = mark - 8'd1;
  assign top_w    = top_pos[7:IW];
  assign top_b    = top_pos[IW-1:0];
  assign top_word = free_map[top_w];
  assign run      = (mark != 8'd0) && top_word[top_b];
  assign cur_bit  = free_map[reg_q[7:IW]][reg_q[IW-1:0]];
  assign out_free = !out_valid || out_ready;

  always_comb begin
    for (int i = 0; i < WB; i++) begin
      rev_inv[i] = ~top_word[WB-1-i];
    end
  end

  // bit i of run_vec is set where position top_b - i is not free, or below the word
  assign run_vec  = (rev_inv >> (IW'(WB - 1) - top_b)) | ~({WB{1'b1}} >> (IW'(WB - 1) - top_b));
  assign scan_vec = ctl.sel_compact ? run_vec : free_map[widx];

  hwrf_scan u_scan (
    .vec   (scan_vec),
    .found (scan_found),
    .idx   (scan_idx)
  );

  assign run_len   = scan_found ? {1'b0, scan_idx} : (IW + 1)'(WB);
  assign keep_lo   = {1'b0, top_b} + (IW + 1)'(1) - run_len;
  assign keep_mask = ~({WB{1'b1}} << keep_lo);

  assign sts.in_valid  = in_valid;
  assign sts.op_free   = (opcode == hwrf_pkg::OP_FREE);
  assign sts.run       = run;
  assign sts.found     = scan_found;
  assign sts.exhausted = (widx == SW'(hwrf_pkg::NUM_WORDS - 1)) || (cnt == 8'd0);
  assign sts.out_free  = out_free;

  hwrf_fsm u_fsm (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .ctl (ctl)
  );

  assign in_ready = ctl.in_ready;

  always_comb begin
    free_map_next   = free_map;
    mark_next       = mark;
    cnt_next        = cnt;
    widx_next       = widx;
    res_given_next  = res_given;
    res_status_next = res_status;

    if (ctl.do_free) begin
      res_given_next  = 8'd0;
      res_status_next = hwrf_pkg::STATUS_OK;
      if ((reg_q >= mark) || cur_bit) begin
        res_status_next = hwrf_pkg::STATUS_BAD_FREE;
      end else if (({1'b0, reg_q} + 9'd1) == {1'b0, mark}) begin
        mark_next = mark - 8'd1;
      end else begin
        free_map_next[reg_q[7:IW]][reg_q[IW-1:0]] = 1'b1;
        cnt_next = cnt + 8'd1;
      end
    end

    if (ctl.sel_compact) begin
      widx_next = '0;
    end

    if (ctl.do_compact) begin
      mark_next            = mark - 8'(run_len);
      cnt_next             = cnt - 8'(run_len);
      free_map_next[top_w] = top_word & keep_mask;
    end

    if (ctl.do_search) begin
      res_status_next = hwrf_pkg::STATUS_OK;
      if (scan_found) begin
        res_given_next = {widx, scan_idx};
        free_map_next[widx][scan_idx] = 1'b0;
        cnt_next = cnt - 8'd1;
      end else if (sts.exhausted) begin
        if (mark >= hwrf_pkg::MARK_LIMIT) begin
          res_given_next  = 8'd0;
          res_status_next = hwrf_pkg::STATUS_FULL;
        end else begin
          res_given_next = mark;
          mark_next      = mark + 8'd1;
        end
      end else begin
        widx_next = widx + SW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_map  <= '0;
      mark      <= 8'd0;
      cnt       <= 8'd0;
      out_valid <= 1'b0;
    end else begin
      free_map <= free_map_next;
      mark     <= mark_next;
      cnt      <= cnt_next;
      if (ctl.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    widx       <= widx_next;
    res_given  <= res_given_next;
    res_status <= res_status_next;
    if (in_valid && ctl.in_ready) begin
      reg_q     <= reg_addr;
      op_free_q <= sts.op_free;
    end
    if (ctl.load_out) begin
      given_reg    <= res_given;
      status       <= res_status;
      in_use_count <= mark - cnt;
      mark_out     <= mark;
    end
  end

  a_cnt_le_mark: assert property (@(posedge clk) disable iff (rst) cnt <= mark)
    else $error("free count exceeds mark");

  a_cnt_matches_map: assert property (@(posedge clk) disable iff (rst)
    $countones(free_map) == cnt)
    else $error("free count out of step with free map");

  a_map_below_mark: assert property (@(posedge clk) disable iff (rst)
    (free_map >> mark) == '0)
    else $error("free bit at or above mark");

  a_full_at_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == hwrf_pkg::STATUS_FULL) |-> mark_out >= hwrf_pkg::MARK_LIMIT)
    else $error("full reported below limit");

  a_free_path: assert property (@(posedge clk) disable iff (rst)
    ctl.do_free |-> op_free_q)
    else $error("free step on an allocate");

endmodule

FILE: verif/high_water_register_free_list_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// high_water_register_free_list_core_tb
// Checks the register allocator against an in-bench model of the mark and
// free map. A directed table covers reset, rejected and double frees, mark
// drops and compaction. Random segments then fill to the limit, mix and
// drain, under changing sender and receiver idle rates and one long stall.
// ---------------------------------------------------------------------------
module high_water_register_free_list_core_tb;

  typedef struct packed {
    logic [7:0]        given;
    hwrf_pkg::status_t status;
    logic [7:0]        in_use;
    logic [7:0]        mark;
  } result_t;

  typedef struct packed {
    hwrf_pkg::op_t op;
    logic [7:0]    addr;
    logic          typed;
    result_t       res;
  } dir_row_t;

  localparam int NUM_DIR       = 24;
  localparam int RANDOM_ITEMS  = 1200;
  localparam int HOLD_CYCLES   = 600;
  localparam int WATCHDOG_MAX  = 4000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int EXP_DEPTH     = 4096;

  localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
    '{hwrf_pkg::OP_ALLOC, 8'd0,   1'b1, '{8'd0, hwrf_pkg::STATUS_OK,       8'd1, 8'd1}},
    '{hwrf_pkg::OP_FREE,  8'd255, 1'b1, '{8'd0, hwrf_pkg::STATUS_BAD_FREE, 8'd1, 8'd1}},
    '{hwrf_pkg::OP_FREE,  8'd1,   1'b1, '{8'd0, hwrf_pkg::STATUS_BAD_FREE, 8'd1, 8'd1}},
    '{hwrf_pkg::OP_ALLOC, 8'd0,   1'b1, '{8'd1, hwrf_pkg::STATUS_OK,       8'd2, 8'd2}},
    '{hwrf_pkg::OP_ALLOC, 8'd0,   1'b1, '{8'd2, hwrf_pkg::STATUS_OK,       8'd3, 8'd3}},
    '{hwrf_pkg::OP_ALLOC, 8'd0,   1'b1, '{8'd3, hwrf_pkg::STATUS_OK,       8'd4, 8'd4}},
    '{hwrf_pkg::OP_FREE,  8'd1,   1'b1, '{8'd0, hwrf_pkg::STATUS_OK,       8'd3, 8'd4}},
    '{hwrf_pkg::OP_FREE,  8'd1,   1'b1, '{8'd0, hwrf_pkg::STATUS_BAD_FREE, 8'd3, 8'd4}},
    '{hwrf_pkg::OP_FREE,  8'd3,   1'b1, '{8'd0, hwrf_pkg::STATUS_OK,       8'd2, 8'd3}},
    '{hwrf_pkg::OP_FREE,  8'd2,   1'b1, '{8'd0, hwrf_pkg::STATUS_OK,       8'd1, 8'd2}},
    '{hwrf_pkg::OP_FREE,  8'd1,   1'b1, '{8'd0, hwrf_pkg::STATUS_BAD_FREE, 8'd1, 8'd2}},
    '{hwrf_pkg::OP_ALLOC, 8'd0,   1'b1, '{8'd1, hwrf_pkg::STATUS_OK,       8'd2, 8'd2}},
    '{hwrf_pkg::OP_FREE,  8'd0,   1'b1, '{8'd0, hwrf_pkg::STATUS_OK,       8'd1, 8'd2}},
    '{hwrf_pkg::OP_ALLOC, 8'd0,   1'b1, '{8'd0, hwrf_pkg::STATUS_OK,       8'd2, 8'd2}},
    '{hwrf_pkg::OP_FREE,  8'd0,   1'b1, '{8'd0, hwrf_pkg::STATUS_OK,       8'd1, 8'd2}},
    '{hwrf_pkg::OP_FREE,  8'd1,   1'b1, '{8'd0, hwrf_pkg::STATUS_OK,       8'd0, 8'd1}},
    '{hwrf_pkg::OP_ALLOC, 8'd0,   1'b1, '{8'd0, hwrf_pkg::STATUS_OK,       8'd1, 8'd1}},
    '{hwrf_pkg::OP_FREE,  8'd0,   1'b1, '{8'd0, hwrf_pkg::STATUS_OK,       8'd0, 8'd0}},
    '{hwrf_pkg::OP_FREE,  8'd0,   1'b1, '{8'd0, hwrf_pkg::STATUS_BAD_FREE, 8'd0, 8'd0}},
    '{hwrf_pkg::OP_ALLOC, 8'hFF,  1'b1, '{8'd0, hwrf_pkg::STATUS_OK,       8'd1, 8'd1}},
    '{hwrf_pkg::OP_ALLOC, 8'hAA,  1'b0, '0},
    '{hwrf_pkg::OP_ALLOC, 8'h55,  1'b0, '0},
    '{hwrf_pkg::OP_FREE,  8'd1,   1'b0, '0},
    '{hwrf_pkg::OP_ALLOC, 8'd0,   1'b0, '0}
  };

  localparam int IDLE_PCT  [4] = '{0, 74, 0, 26};
  localparam int STALL_PCT [4] = '{0, 0, 74, 26};

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       opcode = 1'b0;
  logic [7:0] reg_addr = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] given_reg;
  logic [1:0] status;
  logic [7:0] in_use_count;
  logic [7:0] mark_out;

  int         mdl_mark;
  logic [255:0] mdl_free;
  result_t    exp_results [EXP_DEPTH];
  int         exp_wr = 0;
  int         exp_rd = 0;
  int         idle_pct;
  int         stall_pct = 0;
  int         hold_token = 0;
  int         hold_seen = 0;
  int         hold_left = 0;
  int         errors = 0;
  int         items_sent = 0;
  int         results_checked = 0;
  int         full_seen = 0;
  int         bad_free_seen = 0;
  int         peak_mark = 0;
  int         quiet_cycles = 0;

  high_water_register_free_list_core u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .reg_addr     (reg_addr),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .given_reg    (given_reg),
    .status       (status),
    .in_use_count (in_use_count),
    .mark_out     (mark_out)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic result_t alloc_or_free(hwrf_pkg::op_t op, logic [7:0] addr);
    result_t res;
    int      r;
    int      n_free;
    bit      found;
    res = '{8'd0, hwrf_pkg::STATUS_OK, 8'd0, 8'd0};
    found = 1'b0;
    if (op == hwrf_pkg::OP_FREE) begin
      if (int'(addr) >= mdl_mark || mdl_free[addr]) begin
        res.status = hwrf_pkg::STATUS_BAD_FREE;
      end else if (int'(addr) + 1 == mdl_mark) begin
        mdl_mark--;
      end else begin
        mdl_free[addr] = 1'b1;
      end
    end else begin
      while (mdl_mark > 0 && mdl_free[mdl_mark - 1]) begin
        mdl_free[mdl_mark - 1] = 1'b0;
        mdl_mark--;
      end
      for (r = 0; r < mdl_mark; r++) begin
        if (mdl_free[r]) begin
          found = 1'b1;
          break;
        end
      end
      if (found) begin
        mdl_free[r] = 1'b0;
        res.given = 8'(r);
      end else if (mdl_mark >= hwrf_pkg::REG_LIMIT || mdl_mark >= hwrf_pkg::MARK_MAX) begin
        res.status = hwrf_pkg::STATUS_FULL;
      end else begin
        res.given = 8'(mdl_mark);
        mdl_mark++;
      end
    end
    n_free = 0;
    for (int i = 0; i < mdl_mark; i++) begin
      if (mdl_free[i]) n_free++;
    end
    res.in_use = 8'(mdl_mark - n_free);
    res.mark = 8'(mdl_mark);
    if (mdl_mark > peak_mark) peak_mark = mdl_mark;
    return res;
  endfunction

  function automatic logic [7:0] pick_free_target();
    int pick;
    int start;
    int idx;
    pick = $urandom_range(0, 99);
    if (pick < 10 || mdl_mark == 0) begin
      return 8'($urandom_range(0, 255));
    end
    if (pick < 18) begin
      if (mdl_free != '0 && $urandom_range(0, 1) == 0) begin
        start = $urandom_range(0, 255);
        for (int i = 0; i < 256; i++) begin
          idx = (start + i) % 256;
          if (mdl_free[idx]) return 8'(idx);
        end
      end
      return 8'($urandom_range(mdl_mark, 255));
    end
    if (pick < 35) begin
      return 8'(mdl_mark - 1);
    end
    start = $urandom_range(0, mdl_mark - 1);
    for (int i = 0; i < mdl_mark; i++) begin
      idx = (start + i) % mdl_mark;
      if (!mdl_free[idx]) return 8'(idx);
    end
    return 8'(start);
  endfunction

  task automatic send_item(hwrf_pkg::op_t op, logic [7:0] addr, logic typed,
                           result_t typed_res);
    result_t predicted;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    reg_addr <= addr;
    do @(posedge clk); while (!in_ready);
    predicted = alloc_or_free(op, addr);
    exp_results[exp_wr % EXP_DEPTH] = typed ? typed_res : predicted;
    exp_wr++;
    items_sent++;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (exp_rd == exp_wr) begin
        $error("result with nothing expected: given_reg %0d status %0d", given_reg, status);
        errors++;
      end else begin
        result_t want;
        want = exp_results[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (given_reg !== want.given) begin
          $error("given_reg: expected %0d, actual %0d", want.given, given_reg);
          errors++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status);
          errors++;
        end
        if (in_use_count !== want.in_use) begin
          $error("in_use_count: expected %0d, actual %0d", want.in_use, in_use_count);
          errors++;
        end
        if (mark_out !== want.mark) begin
          $error("mark_out: expected %0d, actual %0d", want.mark, mark_out);
          errors++;
        end
        if (status == hwrf_pkg::STATUS_FULL) full_seen++;
        if (status == hwrf_pkg::STATUS_BAD_FREE) bad_free_seen++;
        results_checked++;
      end
    end
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_MAX) begin
      $display("Watchdog: no transfer for %0d cycles", WATCHDOG_MAX);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int mode;
    int seg;
    int seg_len;
    int alloc_pct;
    int random_sent;
    mdl_mark = 0;
    mdl_free = '0;
    idle_pct = 0;
    seg = 0;
    random_sent = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < NUM_DIR; i++) begin
      send_item(DIR_ROWS[i].op, DIR_ROWS[i].addr, DIR_ROWS[i].typed, DIR_ROWS[i].res);
    end

    while (random_sent < RANDOM_ITEMS) begin
      mode = seg % 4;
      idle_pct = IDLE_PCT[mode];
      stall_pct <= STALL_PCT[mode];
      if (seg == 0) begin
        // fill to the limit while the receiver holds off for a long stretch
        alloc_pct = 97;
        seg_len = 300;
        hold_token <= hold_token + 1;
      end else begin
        case ($urandom_range(0, 2))
          0: alloc_pct = 97;
          1: alloc_pct = 60;
          default: alloc_pct = 25;
        endcase
        seg_len = $urandom_range(80, 200);
      end
      for (int i = 0; i < seg_len; i++) begin
        if ($urandom_range(0, 99) < alloc_pct) begin
          send_item(hwrf_pkg::OP_ALLOC, 8'($urandom_range(0, 255)), 1'b0, '0);
        end else begin
          send_item(hwrf_pkg::OP_FREE, pick_free_target(), 1'b0, '0);
        end
      end
      random_sent += seg_len;
      seg++;
    end

    in_valid <= 1'b0;
    while (exp_rd != exp_wr) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d items in %0d segments, %0d results checked, peak mark %0d",
             items_sent, seg, results_checked, peak_mark);
    $display("Saw %0d full allocates and %0d rejected frees", full_seen, bad_free_seen);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/hwrf_pkg.sv
rtl/hwrf_scan.sv
rtl/hwrf_fsm.sv
rtl/high_water_register_free_list_core.sv
verif/high_water_register_free_list_core_tb.sv
